### rtl/utf8sd_pkg.sv
package utf8sd_pkg;

  localparam logic [20:0] ERROR_CP  = 21'h00FFFD;
  localparam logic [20:0] SURR_LO   = 21'h00D800;
  localparam logic [20:0] SURR_HI   = 21'h00DFFF;
  localparam logic [7:0]  CONT_LO   = 8'h80;
  localparam logic [7:0]  CONT_HI   = 8'hBF;
  localparam logic [7:0]  LEAD2_VAL = 8'hC0;
  localparam logic [7:0]  LEAD2_MSK = 8'hE0;
  localparam logic [7:0]  LEAD3_VAL = 8'hE0;
  localparam logic [7:0]  LEAD3_MSK = 8'hF0;
  localparam logic [7:0]  LEAD4_VAL = 8'hF0;
  localparam logic [7:0]  LEAD4_MSK = 8'hF8;
  localparam logic [7:0]  LEAD2_BITS = 8'h1F;
  localparam logic [7:0]  LEAD3_BITS = 8'h0F;
  localparam logic [7:0]  LEAD4_BITS = 8'h07;
  localparam logic [7:0]  CONT_BITS  = 8'h3F;

  localparam logic [2:0]  LEN_NONE = 3'd0;
  localparam logic [2:0]  LEN_1    = 3'd1;
  localparam logic [2:0]  LEN_2    = 3'd2;
  localparam logic [2:0]  LEN_3    = 3'd3;
  localparam logic [2:0]  LEN_4    = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        is_error;
    logic [2:0]  byte_count;
    logic        last_of_run;
  } out_item_t;

  // Results of one byte: err_cnt error results, then an optional good one.
  typedef struct packed {
    logic [2:0]  err_cnt;
    logic        has_good;
    logic [20:0] good_cp;
    logic [2:0]  good_len;
  } run_t;

endpackage

### rtl/utf8sd_decode.sv
module utf8sd_decode
  import utf8sd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     advance,
  input  in_item_t item,
  output run_t     run
);

  logic [20:0] pv_r, pv_nxt;
  logic [2:0]  el_r, el_nxt;
  logic [1:0]  cc_r, cc_nxt;

  logic [7:0]  b;
  logic        eos;
  logic        is_cont;
  logic [20:0] pv_sh;
  logic [1:0]  cc_inc;
  logic        done;
  logic        surr;

  assign b       = item.data_byte;
  assign eos     = item.end_of_stream;
  assign is_cont = (b >= CONT_LO) && (b <= CONT_HI);
  assign pv_sh   = {pv_r[14:0], b[5:0] & CONT_BITS[5:0]};
  assign cc_inc  = cc_r + 2'd1;
  assign done    = ({1'b0, cc_inc} + 3'd1) >= el_r;
  assign surr    = (pv_sh >= SURR_LO) && (pv_sh <= SURR_HI);

  always_comb begin
    logic consumed;
    consumed      = 1'b0;
    pv_nxt        = pv_r;
    el_nxt        = el_r;
    cc_nxt        = cc_r;
    run.err_cnt   = 3'd0;
    run.has_good  = 1'b0;
    run.good_cp   = pv_sh;
    run.good_len  = el_r;

    if (el_r != LEN_NONE) begin
      if (is_cont) begin
        consumed = 1'b1;
        if (done || eos) begin
          // sequence ends here: good value or one error per byte taken
          if (done && !surr) begin
            run.has_good = 1'b1;
          end else begin
            run.err_cnt = {1'b0, cc_inc} + 3'd1;
          end
          pv_nxt = '0;
          el_nxt = LEN_NONE;
          cc_nxt = 2'd0;
        end else begin
          pv_nxt = pv_sh;
          cc_nxt = cc_inc;
        end
      end else begin
        run.err_cnt = {1'b0, cc_r} + 3'd1;
        pv_nxt = '0;
        el_nxt = LEN_NONE;
        cc_nxt = 2'd0;
      end
    end

    if (!consumed) begin
      if (b[7] == 1'b0) begin
        run.has_good = 1'b1;
        run.good_cp  = {13'd0, b};
        run.good_len = LEN_1;
      end else if ((b & LEAD2_MSK) == LEAD2_VAL) begin
        pv_nxt = {13'd0, b & LEAD2_BITS};
        el_nxt = LEN_2;
        cc_nxt = 2'd0;
      end else if ((b & LEAD3_MSK) == LEAD3_VAL) begin
        pv_nxt = {13'd0, b & LEAD3_BITS};
        el_nxt = LEN_3;
        cc_nxt = 2'd0;
      end else if ((b & LEAD4_MSK) == LEAD4_VAL) begin
        pv_nxt = {13'd0, b & LEAD4_BITS};
        el_nxt = LEN_4;
        cc_nxt = 2'd0;
      end else begin
        run.err_cnt = run.err_cnt + 3'd1;
      end
      // a lead right at end of stream is a truncated sequence
      if (eos && el_nxt != LEN_NONE) begin
        run.err_cnt = run.err_cnt + 3'd1;
        pv_nxt = '0;
        el_nxt = LEN_NONE;
        cc_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
      el_r <= LEN_NONE;
      cc_r <= 2'd0;
    end else if (advance) begin
      pv_r <= pv_nxt;
      el_r <= el_nxt;
      cc_r <= cc_nxt;
    end
  end

endmodule

### rtl/utf8sd_emit.sv
module utf8sd_emit
  import utf8sd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  run_t      run,
  output logic      free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic [2:0]  err_cnt_r, err_cnt_nxt;
  logic        has_good_r, has_good_nxt;
  logic [20:0] good_cp_r;
  logic [2:0]  good_len_r;
  logic        last;

  assign out_valid = (err_cnt_r != 3'd0) || has_good_r;
  assign last      = (err_cnt_r == 3'd0) || ((err_cnt_r == 3'd1) && !has_good_r);
  assign free      = !out_valid || (out_ready && last);

  always_comb begin
    if (err_cnt_r != 3'd0) begin
      out_data.code_point = ERROR_CP;
      out_data.is_error   = 1'b1;
      out_data.byte_count = 3'd0;
    end else begin
      out_data.code_point = good_cp_r;
      out_data.is_error   = 1'b0;
      out_data.byte_count = good_len_r;
    end
    out_data.last_of_run = last;
  end

  always_comb begin
    err_cnt_nxt  = err_cnt_r;
    has_good_nxt = has_good_r;
    if (load) begin
      err_cnt_nxt  = run.err_cnt;
      has_good_nxt = run.has_good;
    end else if (out_valid && out_ready) begin
      if (err_cnt_r != 3'd0) begin
        err_cnt_nxt = err_cnt_r - 3'd1;
      end else begin
        has_good_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_cnt_r  <= 3'd0;
      has_good_r <= 1'b0;
    end else begin
      err_cnt_r  <= err_cnt_nxt;
      has_good_r <= has_good_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      good_cp_r  <= run.good_cp;
      good_len_r <= run.good_len;
    end
  end

endmodule

### rtl/utf8_stream_decoder.sv
// Channel  | Signals                         | Payload
// ---------+---------------------------------+------------------------------
// input    | in_valid, in_ready, in_data     | data_byte, end_of_stream
// output   | out_valid, out_ready, out_data  | code_point, is_error,
//          |                                 | byte_count, last_of_run
//
// One byte is accepted per cycle unless the held byte cannot move on. A byte
// is loaded into the result register once that is free; its first result
// shows from there. A byte that yields k results holds the result register
// until all k are taken (k is at most 4), so input backs up behind an error flush.
// rst_n is synchronous: it clears the pending sequence and both valid stages.
// With out_ready low one byte still waits in the input register.
module utf8_stream_decoder
  import utf8sd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic     in_vld_r, in_vld_nxt;
  in_item_t item_r;
  logic     run_free;
  logic     advance;
  run_t     run;

  assign advance  = in_vld_r && run_free;
  assign in_ready = !in_vld_r || run_free;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_valid && in_ready) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  utf8sd_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .run     (run)
  );

  utf8sd_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .run       (run),
    .free      (run_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/sv/utf8_stream_decoder_tb.sv
`timescale 1ns / 100ps

module utf8_stream_decoder_tb;
  import utf8sd_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_TAIL  = 10;
  localparam int TOTAL_BYTES = 410;
  localparam int HOLD_CYCLES = 80;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // decoder shadow state
  logic [20:0] seq_val;
  logic [2:0]  seq_len;
  logic [1:0]  seq_got;

  out_item_t burst[4];
  int        burst_n;
  out_item_t pending_points[$];

  int  bytes_sent;
  int  bad_results;
  int  quiet_cycles;
  bit  idle_on;
  bit  hold_req;

  utf8_stream_decoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void emit_point(logic [20:0] cp, logic err, logic [2:0] cnt);
    out_item_t r;
    if (burst_n < 4) begin
      r.code_point  = cp;
      r.is_error    = err;
      r.byte_count  = cnt;
      r.last_of_run = 1'b0;
      burst[burst_n] = r;
      burst_n++;
    end
  endfunction

  // one error for the lead, one per buffered continuation
  function automatic void abort_sequence();
    emit_point(ERROR_CP, 1'b1, LEN_NONE);
    for (int k = 0; k < int'(seq_got); k++) begin
      emit_point(ERROR_CP, 1'b1, LEN_NONE);
    end
    seq_val = '0;
    seq_len = LEN_NONE;
    seq_got = '0;
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic eos);
    bit taken;
    out_item_t r;
    taken   = 1'b0;
    burst_n = 0;
    if (seq_len != LEN_NONE) begin
      if (b >= CONT_LO && b <= CONT_HI) begin
        taken   = 1'b1;
        seq_val = (seq_val << 6) | {13'd0, b & CONT_BITS};
        seq_got = seq_got + 2'd1;
        if ({1'b0, seq_got} + 3'd1 >= seq_len) begin
          if (seq_val >= SURR_LO && seq_val <= SURR_HI) begin
            abort_sequence();
          end else begin
            emit_point(seq_val, 1'b0, seq_len);
            seq_val = '0;
            seq_len = LEN_NONE;
            seq_got = '0;
          end
        end else if (eos) begin
          abort_sequence();
        end
      end else begin
        abort_sequence();
      end
    end
    if (!taken) begin
      if (b < CONT_LO) begin
        emit_point({13'd0, b}, 1'b0, LEN_1);
      end else if ((b & LEAD2_MSK) == LEAD2_VAL) begin
        seq_val = {13'd0, b & LEAD2_BITS};
        seq_len = LEN_2;
        seq_got = '0;
      end else if ((b & LEAD3_MSK) == LEAD3_VAL) begin
        seq_val = {13'd0, b & LEAD3_BITS};
        seq_len = LEN_3;
        seq_got = '0;
      end else if ((b & LEAD4_MSK) == LEAD4_VAL) begin
        seq_val = {13'd0, b & LEAD4_BITS};
        seq_len = LEN_4;
        seq_got = '0;
      end else begin
        emit_point(ERROR_CP, 1'b1, LEN_NONE);
      end
      if (eos && seq_len != LEN_NONE) begin
        abort_sequence();
      end
    end
    for (int i = 0; i < burst_n; i++) begin
      r = burst[i];
      r.last_of_run = (i == burst_n - 1);
      pending_points.push_back(r);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = '{data_byte: b, end_of_stream: eos};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b, eos);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  function automatic logic rand_eos();
    return ($urandom_range(0, 24) == 0);
  endfunction

  // mostly well-formed sequences with random payload, some broken ones and noise
  task automatic send_random_seq();
    logic [7:0] seq_bytes[4];
    int n;
    int len;
    int r;
    r = $urandom_range(0, 99);
    n = 1;
    if (r < 30) begin
      seq_bytes[0] = 8'($urandom_range(0, 8'h7F));
    end else if (r < 82) begin
      len = (r < 50) ? 2 : (r < 70) ? 3 : 4;
      n   = len;
    end else if (r < 91) begin
      len = $urandom_range(2, 4);
      n   = $urandom_range(1, len - 1);
    end else begin
      seq_bytes[0] = 8'($urandom_range(0, 255));
    end
    if (r >= 30 && r < 91) begin
      case (len)
        2:       seq_bytes[0] = LEAD2_VAL | 8'($urandom_range(0, 31));
        3:       seq_bytes[0] = LEAD3_VAL | 8'($urandom_range(0, 15));
        default: seq_bytes[0] = LEAD4_VAL | 8'($urandom_range(0, 7));
      endcase
      for (int i = 1; i < n; i++) begin
        seq_bytes[i] = CONT_LO | 8'($urandom_range(0, 63));
      end
    end
    for (int i = 0; i < n; i++) begin
      send_byte(seq_bytes[i], rand_eos());
    end
  endtask

  task automatic test_ascii_bounds();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'h41, 1'b1);
    wait_drained();
  endtask

  task automatic test_valid_sequences();
    // overlong two-byte zero, top of each length, top of the F5-F7 leads
    send_byte(8'hC0, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hDF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hEF, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hF7, 1'b0); send_byte(8'hBF, 1'b0); send_byte(8'hBF, 1'b0);
    send_byte(8'hBF, 1'b0);
    wait_drained();
  endtask

  task automatic test_error_cases();
    // stray continuation and invalid lead
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    // encoded surrogate
    send_byte(8'hED, 1'b0); send_byte(8'hA0, 1'b0); send_byte(8'h80, 1'b0);
    // bad continuation after two buffered bytes, then a lead cut off by end of stream
    send_byte(8'hF0, 1'b0); send_byte(8'h90, 1'b0); send_byte(8'h80, 1'b0);
    send_byte(8'hC2, 1'b1);
    // ascii interrupts a three-byte sequence
    send_byte(8'hE2, 1'b0); send_byte(8'h41, 1'b0);
    // truncated at end of stream
    send_byte(8'hE2, 1'b0); send_byte(8'h82, 1'b1);
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    int start;
    idle_on  = 1'b0;
    hold_req = 1'b1;
    start    = bytes_sent;
    while (bytes_sent - start < 40) send_random_seq();
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_random_stream();
    int next_switch;
    next_switch = bytes_sent + $urandom_range(20, 60);
    while (bytes_sent < TOTAL_BYTES) begin
      if (bytes_sent >= next_switch) begin
        idle_on     = ~idle_on;
        next_switch = bytes_sent + $urandom_range(20, 60);
      end
      if ($urandom_range(0, 99) < 4) wait_drained();
      send_random_seq();
    end
    wait_drained();
  endtask

  // result side: random stalls, plus a long hold-off on request
  initial begin
    int stall;
    out_ready = 1'b0;
    stall     = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        stall    = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else begin
        out_ready = 1'b1;
        stall     = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_points.size() == 0) begin
        bad_results++;
        if (bad_results <= 10) begin
          $display("unexpected result: cp=%h err=%0d cnt=%0d last=%0d",
                   out_data.code_point, out_data.is_error, out_data.byte_count,
                   out_data.last_of_run);
        end
      end else begin
        want = pending_points.pop_front();
        if (out_data.code_point !== want.code_point || out_data.is_error !== want.is_error ||
            out_data.byte_count !== want.byte_count ||
            out_data.last_of_run !== want.last_of_run) begin
          bad_results++;
          if (bad_results <= 10) begin
            $display("mismatch: exp cp=%h err=%0d cnt=%0d last=%0d", want.code_point,
                     want.is_error, want.byte_count, want.last_of_run);
            $display("          got cp=%h err=%0d cnt=%0d last=%0d", out_data.code_point,
                     out_data.is_error, out_data.byte_count, out_data.last_of_run);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    seq_val      = '0;
    seq_len      = LEN_NONE;
    seq_got      = '0;
    bytes_sent   = 0;
    bad_results  = 0;
    quiet_cycles = 0;
    idle_on      = 1'b1;
    hold_req     = 1'b0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_ascii_bounds();
    test_valid_sequences();
    test_error_cases();
    test_output_backpressure();
    test_random_stream();

    if (bad_results == 0 && pending_points.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
rtl/utf8sd_pkg.sv
rtl/utf8sd_decode.sv
rtl/utf8sd_emit.sv
rtl/utf8_stream_decoder.sv
tb/sv/utf8_stream_decoder_tb.sv
